// File: hw/rtl/ehsc_pkg.sv
// shared types and constants for the elf hash table symbol count block
`timescale 1ns / 1ps
`default_nettype none

package ehsc_pkg;

  // field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned INDEX_W = 28;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // internal widths
  localparam int unsigned BASE_W = 22;   // 4 + filter words + bucket count
  localparam int unsigned TGT_W  = INDEX_W + 1;
  localparam int unsigned SUM_W  = WORD_W + 2;

  // largest symbol count accepted
  localparam logic [WORD_W-1:0] SYMBOL_LIMIT = 32'd1048576;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_KIND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_WORDS = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_TRUNC_HDR    = 3'd1,
    ST_SYSV_LIMIT   = 3'd2,
    ST_SYSV_TRUNC   = 3'd3,
    ST_GNU_DIMS     = 3'd4,
    ST_GNU_SHORT    = 3'd5,
    ST_GNU_BUCKET   = 3'd6,
    ST_CHAIN_BAD    = 3'd7
  } status_e;

  // walk phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYSV   = 3'd1,
    PH_GHDR   = 3'd2,
    PH_BLOOM  = 3'd3,
    PH_BUCKET = 3'd4,
    PH_SEEK   = 3'd5,
    PH_CHAIN  = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

endpackage

`default_nettype wire

// File: hw/rtl/elf_hash_table_symbol_count.sv
// top level: derives the dynamic symbol count from a streamed elf32 hash table
`timescale 1ns / 1ps
`default_nettype none

// Takes one 32-bit table word per cycle on the input channel unless stalled;
// first_word_i marks word zero of a new table. Each word goes through an input
// register, is checked combinationally against the running table state and, when it
// decides the answer, loads the result register. After a result, words are dropped
// until the next first word. The input side stalls only while a result waits unread
// in the result register. Configuration (table kind, table length in words) must be
// written only while the block is idle; the block itself does not enforce this. The
// configuration port is always ready.
module elf_hash_table_symbol_count (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ehsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ehsc_pkg::INDEX_W-1:0]   cfg_data_i,
  // table word channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ehsc_pkg::WORD_W-1:0]    table_word_i,
  input  wire logic                           first_word_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ehsc_pkg::COUNT_W-1:0]        sym_count_o,
  output logic [ehsc_pkg::STAT_W-1:0]         status_o
);
  import ehsc_pkg::*;

  // configuration registers
  logic               kind_q;
  logic [INDEX_W-1:0] tw_q;

  // input register
  logic              s1_valid_q;
  logic [WORD_W-1:0] s1_word_q;
  logic              s1_first_q;

  // table state
  phase_e             phase_q, phase_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic [WORD_W-1:0]  bucket_q, bucket_d;
  logic [COUNT_W-1:0] first_off_q, first_off_d;
  logic [COUNT_W-1:0] filter_q, filter_d;
  logic [COUNT_W-1:0] highest_q, highest_d;
  logic [COUNT_W-1:0] walk_q, walk_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [TGT_W-1:0]   target_q, target_d;

  // result register
  logic               out_valid_q;
  logic [COUNT_W-1:0] count_q;
  logic [STAT_W-1:0]  status_q;

  // combinational results
  logic               proc_fire;
  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  status_e            res_status;

  logic               active;
  phase_e             cur_phase;
  logic [INDEX_W-1:0] idx;
  logic [TGT_W-1:0]   idx1;
  logic [TGT_W-1:0]   tw_ext;
  logic               word_over;
  logic [SUM_W-1:0]   sysv_need;
  logic [COUNT_W-1:0] word_cnt;
  logic [COUNT_W-1:0] hmax;
  logic [COUNT_W-1:0] walk_inc;
  logic [TGT_W-1:0]   new_target;
  logic [BASE_W-1:0]  bloom_end;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign proc_fire   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || proc_fire;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
      tw_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TABLE_KIND:  kind_q <= cfg_data_i[0];
        REG_TABLE_WORDS: tw_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q  <= table_word_i;
      s1_first_q <= first_word_i;
    end
  end

  // shared terms of the word check
  assign cur_phase = s1_first_q ? (kind_q ? PH_GHDR : PH_SYSV) : phase_q;
  assign active    = s1_first_q || (phase_q != PH_IDLE && phase_q != PH_DONE);
  assign idx       = s1_first_q ? '0 : idx_q;
  assign idx1      = {1'b0, idx} + TGT_W'(1);
  assign tw_ext    = {1'b0, tw_q};
  assign word_over = s1_word_q > SYMBOL_LIMIT;
  assign word_cnt  = s1_word_q[COUNT_W-1:0];
  assign sysv_need = SUM_W'(2) + SUM_W'(bucket_q) + SUM_W'(s1_word_q);
  assign bloom_end = BASE_W'(3) + BASE_W'(filter_q);
  assign hmax      = (s1_word_q != '0 && word_cnt > highest_q) ? word_cnt : highest_q;
  assign new_target = TGT_W'(base_q) + TGT_W'(hmax - first_off_q);
  assign walk_inc  = walk_q + COUNT_W'(1);

  // per-word table walk
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    bucket_d    = bucket_q;
    first_off_d = first_off_q;
    filter_d    = filter_q;
    highest_d   = highest_q;
    walk_d      = walk_q;
    base_d      = base_q;
    target_d    = target_q;
    res_valid   = 1'b0;
    res_count   = '0;
    res_status  = ST_OK;

    if (active) begin
      // restart on word zero
      if (s1_first_q) begin
        bucket_d    = '0;
        first_off_d = '0;
        filter_d    = '0;
        highest_d   = '0;
        walk_d      = '0;
        phase_d     = cur_phase;
      end
      idx_d = idx1[INDEX_W-1:0];

      if (idx == '0) begin
        // bucket count word
        if (cur_phase == PH_SYSV && tw_q < INDEX_W'(2)) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNC_HDR;
        end else if (cur_phase != PH_SYSV && tw_q < INDEX_W'(4)) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNC_HDR;
        end else if (cur_phase != PH_SYSV && word_over) begin
          res_valid  = 1'b1;
          res_status = ST_GNU_DIMS;
        end else begin
          bucket_d = s1_word_q;
        end
      end else begin
        unique case (cur_phase)
          PH_SYSV: begin
            // chain count word
            res_valid = 1'b1;
            if (word_over) begin
              res_status = ST_SYSV_LIMIT;
            end else if (sysv_need > SUM_W'(tw_q)) begin
              res_status = ST_SYSV_TRUNC;
            end else begin
              res_count = word_cnt;
            end
          end
          PH_GHDR: begin
            if (idx == INDEX_W'(1)) begin
              // symbol offset word
              if (word_over) begin
                res_valid  = 1'b1;
                res_status = ST_GNU_DIMS;
              end else begin
                first_off_d = word_cnt;
              end
            end else if (idx == INDEX_W'(2)) begin
              // bloom size word
              if (s1_word_q == '0 || word_over) begin
                res_valid  = 1'b1;
                res_status = ST_GNU_DIMS;
              end else begin
                filter_d = word_cnt;
                base_d   = BASE_W'(4) + BASE_W'(word_cnt) + BASE_W'(bucket_q);
              end
            end else if (TGT_W'(base_q) > tw_ext) begin
              res_valid  = 1'b1;
              res_status = ST_GNU_SHORT;
            end else if (bucket_q == '0) begin
              res_valid = 1'b1;
              res_count = first_off_q;
            end else begin
              phase_d = PH_BLOOM;
            end
          end
          PH_BLOOM: begin
            if (TGT_W'(idx) >= TGT_W'(bloom_end)) begin
              phase_d = PH_BUCKET;
            end
          end
          PH_BUCKET: begin
            // bucket word: validate and track the largest start
            if (s1_word_q != '0 &&
                (s1_word_q < WORD_W'(first_off_q) || s1_word_q >= SYMBOL_LIMIT)) begin
              res_valid  = 1'b1;
              res_status = ST_GNU_BUCKET;
            end else begin
              highest_d = hmax;
              if (idx1 >= TGT_W'(base_q)) begin
                if (hmax == '0) begin
                  res_valid = 1'b1;
                  res_count = first_off_q;
                end else begin
                  walk_d   = hmax;
                  target_d = new_target;
                  if (new_target >= tw_ext) begin
                    res_valid  = 1'b1;
                    res_status = ST_CHAIN_BAD;
                  end else begin
                    phase_d = (idx1 >= new_target) ? PH_CHAIN : PH_SEEK;
                  end
                end
              end
            end
          end
          PH_SEEK: begin
            if (idx1 >= target_q) begin
              phase_d = PH_CHAIN;
            end
          end
          PH_CHAIN: begin
            // chain word: bit 0 ends the chain
            if (s1_word_q[0]) begin
              res_valid = 1'b1;
              res_count = walk_inc;
            end else begin
              walk_d   = walk_inc;
              target_d = target_q + TGT_W'(1);
              if (WORD_W'(walk_inc) >= SYMBOL_LIMIT || idx1 >= tw_ext) begin
                res_valid  = 1'b1;
                res_status = ST_CHAIN_BAD;
              end
            end
          end
          default: ;
        endcase
      end

      if (res_valid) begin
        phase_d = PH_DONE;
      end
    end
  end

  // table state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      idx_q       <= '0;
      bucket_q    <= '0;
      first_off_q <= '0;
      filter_q    <= '0;
      highest_q   <= '0;
      walk_q      <= '0;
      base_q      <= '0;
      target_q    <= '0;
    end else if (proc_fire) begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      bucket_q    <= bucket_d;
      first_off_q <= first_off_d;
      filter_q    <= filter_d;
      highest_q   <= highest_d;
      walk_q      <= walk_d;
      base_q      <= base_d;
      target_q    <= target_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res_valid) begin
      count_q  <= res_count;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sym_count_o = count_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
